// ----- rtl/imhd_pkg.sv -----
// shared widths, codes and record types for the indexed min-heap core
package imhd_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W = 10;
  localparam int VAL_W = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_SPACE = 1 << KEY_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DEC    = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_DUP    = 3'd3,
    ST_ABSENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             present;
    logic [IDX_W-1:0] slot;
  } pos_t;

endpackage

// ----- rtl/indexed_min_heap_decrement_core.sv -----
// indexed binary min-heap with insert, decrement-by-one and pop-min
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, op, item_key, item_value | into core
//  out     | out_valid, out_stall, min_key, min_value,    | out of core
//          | status, entry_count                          |
//
// one item at a time; heap slots and the key position table are rams with a registered read
// insert reads the key's position, then climbs one level per read and compare, at most 9 levels;
// decrement first fetches the entry and lowers its value, then climbs like insert;
// pop reads the root and the last entry, then descends one level per left read, right read and compare;
// a lone entry is taken without a descent; flagged ops and op code 3 skip the heap walk
// after reset a pass over every key clears the position table, in_stall stays high
// a held result in the output register blocks only the end of the next item
module indexed_min_heap_decrement_core
  import imhd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [KEY_W-1:0] item_key,
  input  logic [VAL_W-1:0] item_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] min_key,
  output logic [VAL_W-1:0] min_value,
  output logic [2:0]       status,
  output logic [CNT_W-1:0] entry_count
);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_POS     = 12'b0000_0000_0100,
    S_DEC_GET = 12'b0000_0000_1000,
    S_UP_RD   = 12'b0000_0001_0000,
    S_UP_CMP  = 12'b0000_0010_0000,
    S_POP_RL  = 12'b0000_0100_0000,
    S_POP_GL  = 12'b0000_1000_0000,
    S_DN_RL   = 12'b0001_0000_0000,
    S_DN_RR   = 12'b0010_0000_0000,
    S_DN_CMP  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  entry_t heap_mem [CAPACITY];
  pos_t   pos_mem  [KEY_SPACE];

  state_t           state, state_next;
  logic [CNT_W-1:0] size, size_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [IDX_W-1:0] idx, idx_next;
  entry_t           cur, cur_next;
  entry_t           lreg, lreg_next;
  logic             has_r, has_r_next;
  logic [1:0]       req_op, req_op_next;
  logic [KEY_W-1:0] req_key, req_key_next;
  logic [VAL_W-1:0] req_val, req_val_next;
  logic [KEY_W-1:0] rkey, rkey_next;
  logic [VAL_W-1:0] rval, rval_next;
  status_t          st, st_next;

  logic             heap_re, heap_we;
  logic [IDX_W-1:0] heap_raddr, heap_waddr;
  entry_t           heap_wdata, heap_rdata;
  logic             pos_re, pos_we;
  logic [KEY_W-1:0] pos_raddr, pos_waddr;
  pos_t             pos_wdata, pos_rdata;

  logic             load_out;
  logic [IDX_W-1:0] par;
  logic [CNT_W-1:0] lch, rch, size_m1;
  entry_t           pick;
  logic [CNT_W-1:0] pick_idx;

  assign in_stall = (state != S_IDLE);
  assign par      = (idx - IDX_W'(1)) >> 1;
  assign lch      = {idx, 1'b1};
  assign rch      = lch + CNT_W'(1);
  assign size_m1  = size - CNT_W'(1);

  always_comb begin
    if (has_r && (heap_rdata.value < lreg.value)) begin
      pick     = heap_rdata;
      pick_idx = rch;
    end else begin
      pick     = lreg;
      pick_idx = lch;
    end
  end

  always_comb begin
    state_next   = state;
    size_next    = size;
    clr_idx_next = clr_idx;
    idx_next     = idx;
    cur_next     = cur;
    lreg_next    = lreg;
    has_r_next   = has_r;
    req_op_next  = req_op;
    req_key_next = req_key;
    req_val_next = req_val;
    rkey_next    = rkey;
    rval_next    = rval;
    st_next      = st;
    heap_re      = 1'b0;
    heap_raddr   = '0;
    heap_we      = 1'b0;
    heap_waddr   = '0;
    heap_wdata   = '0;
    pos_re       = 1'b0;
    pos_raddr    = '0;
    pos_we       = 1'b0;
    pos_waddr    = '0;
    pos_wdata    = '0;
    load_out     = 1'b0;

    case (state)
      S_CLEAR: begin
        pos_we       = 1'b1;
        pos_waddr    = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_op_next  = op;
          req_key_next = item_key;
          req_val_next = item_value;
          rkey_next    = '0;
          rval_next    = '0;
          st_next      = ST_OK;
          case (op)
            OP_INSERT, OP_DEC: begin
              pos_re     = 1'b1;
              pos_raddr  = item_key;
              state_next = S_POS;
            end
            OP_POP: begin
              if (size == '0) begin
                st_next    = ST_EMPTY;
                state_next = S_DONE;
              end else begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_next = S_POP_RL;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_POS: begin
        if (req_op == OP_INSERT) begin
          if (pos_rdata.present) begin
            st_next    = ST_DUP;
            state_next = S_DONE;
          end else if (size == CNT_W'(CAPACITY)) begin
            st_next    = ST_FULL;
            state_next = S_DONE;
          end else begin
            cur_next   = '{key: req_key, value: req_val};
            idx_next   = size[IDX_W-1:0];
            size_next  = size + CNT_W'(1);
            state_next = S_UP_RD;
          end
        end else begin
          if (!pos_rdata.present || ({1'b0, pos_rdata.slot} >= size)) begin
            st_next    = ST_ABSENT;
            state_next = S_DONE;
          end else begin
            heap_re    = 1'b1;
            heap_raddr = pos_rdata.slot;
            idx_next   = pos_rdata.slot;
            state_next = S_DEC_GET;
          end
        end
      end
      S_DEC_GET: begin
        cur_next.key = heap_rdata.key;
        if (heap_rdata.value != '0) begin
          cur_next.value = heap_rdata.value - VAL_W'(1);
        end else begin
          cur_next.value = '0;
        end
        state_next = S_UP_RD;
      end
      S_UP_RD: begin
        if (idx == '0) begin
          heap_we    = 1'b1;
          heap_waddr = idx;
          heap_wdata = cur;
          pos_we     = 1'b1;
          pos_waddr  = cur.key;
          pos_wdata  = '{present: 1'b1, slot: idx};
          state_next = S_DONE;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = par;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = idx;
        pos_we     = 1'b1;
        pos_wdata  = '{present: 1'b1, slot: idx};
        if (heap_rdata.value > cur.value) begin
          heap_wdata = heap_rdata;
          pos_waddr  = heap_rdata.key;
          idx_next   = par;
          state_next = S_UP_RD;
        end else begin
          heap_wdata = cur;
          pos_waddr  = cur.key;
          state_next = S_DONE;
        end
      end
      S_POP_RL: begin
        rkey_next  = heap_rdata.key;
        rval_next  = heap_rdata.value;
        heap_re    = 1'b1;
        heap_raddr = size_m1[IDX_W-1:0];
        state_next = S_POP_GL;
      end
      S_POP_GL: begin
        pos_we    = 1'b1;
        pos_waddr = rkey;
        pos_wdata = '0;
        size_next = size_m1;
        if (size_m1 == '0) begin
          state_next = S_DONE;
        end else begin
          cur_next   = heap_rdata;
          idx_next   = '0;
          state_next = S_DN_RL;
        end
      end
      S_DN_RL: begin
        if (lch >= size) begin
          heap_we    = 1'b1;
          heap_waddr = idx;
          heap_wdata = cur;
          pos_we     = 1'b1;
          pos_waddr  = cur.key;
          pos_wdata  = '{present: 1'b1, slot: idx};
          state_next = S_DONE;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = lch[IDX_W-1:0];
          state_next = S_DN_RR;
        end
      end
      S_DN_RR: begin
        lreg_next  = heap_rdata;
        has_r_next = (rch < size);
        if (rch < size) begin
          heap_re    = 1'b1;
          heap_raddr = rch[IDX_W-1:0];
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = idx;
        pos_we     = 1'b1;
        pos_wdata  = '{present: 1'b1, slot: idx};
        if (pick.value < cur.value) begin
          heap_wdata = pick;
          pos_waddr  = pick.key;
          idx_next   = pick_idx[IDX_W-1:0];
          state_next = S_DN_RL;
        end else begin
          heap_wdata = cur;
          pos_waddr  = cur.key;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_rdata <= heap_mem[heap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rdata <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      size      <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      size    <= size_next;
      clr_idx <= clr_idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    cur     <= cur_next;
    lreg    <= lreg_next;
    has_r   <= has_r_next;
    req_op  <= req_op_next;
    req_key <= req_key_next;
    req_val <= req_val_next;
    rkey    <= rkey_next;
    rval    <= rval_next;
    st      <= st_next;
    if (load_out) begin
      min_key     <= rkey;
      min_value   <= rval;
      status      <= st;
      entry_count <= size;
    end
  end

  // checks on the sequencer
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside the finish step");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (load_out && st == ST_FULL) |-> (size == CNT_W'(CAPACITY)))
    else $error("full flagged below capacity");

  a_no_heap_write_idle: assert property (@(posedge clk) disable iff (rst)
    heap_we |-> !(state == S_IDLE || state == S_CLEAR || state == S_DONE))
    else $error("heap slot written outside a sift");

endmodule
